// ----- rtl/hsl_to_rgba_converter_defines.svh -----
// ----------------------------------------------------------------------------
// HSL to RGBA converter assertion macros
// Shared property shorthands for the stream checker.
// ----------------------------------------------------------------------------
`ifndef HSL_TO_RGBA_CONVERTER_DEFINES_SVH
`define HSL_TO_RGBA_CONVERTER_DEFINES_SVH

// Same-cycle implication, masked during reset
`define HSL2RGBA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hsl2rgba same-cycle check failed");

// Next-cycle implication, masked during reset
`define HSL2RGBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hsl2rgba next-cycle check failed");

// Next-cycle implication that also covers reset itself
`define HSL2RGBA_ASSERT_RESET(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("hsl2rgba reset check failed");

`endif

// ----- rtl/hsl2rgba_pkg.sv -----
// ----------------------------------------------------------------------------
// HSL to RGBA converter package
// Fixed-point constants, pipeline control type and hue ramp helpers.
// ----------------------------------------------------------------------------
package hsl2rgba_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int NUM_STAGES    = 6;

  // Hue in thirds-scaled units: three full turns per period
  localparam logic [17:0] TURN        = 18'd65536;
  localparam logic [17:0] HALF_TURN   = 18'd32768;
  localparam logic [17:0] RAMP_FALL   = 18'd98304;
  localparam logic [17:0] TWO_TURNS   = 18'd131072;
  localparam logic [18:0] PERIOD      = 19'd196608;
  localparam logic [16:0] K_TOP       = 17'd65536;

  // Rounding and division constants of the 0.16 format
  localparam logic [15:0] UNIT_ONE    = 16'hFFFF;
  localparam logic [15:0] ROUND_BIAS  = 16'd32767;
  localparam logic [16:0] TWO_UNITS   = 17'd131070;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } ctrl_t;

  // Advance the scaled hue by an offset and wrap into one period
  function automatic logic [17:0] wrap_hue(input logic [17:0] th, input logic [17:0] offset);
    logic [18:0] sum;
    logic [18:0] wrapped;
    sum     = {1'b0, th} + {1'b0, offset};
    wrapped = (sum >= PERIOD) ? (sum - PERIOD) : sum;
    return wrapped[17:0];
  endfunction

  // Piecewise hue weight: rise, flat top, fall, then zero
  function automatic logic [16:0] hue_ramp(input logic [17:0] t);
    logic [17:0] fall;
    fall = TWO_TURNS - t;
    if (t < HALF_TURN)
      return {t[15:0], 1'b0};
    else if (t < RAMP_FALL)
      return K_TOP;
    else if (t < TWO_TURNS)
      return {fall[15:0], 1'b0};
    else
      return 17'd0;
  endfunction

endpackage

// ----- rtl/hsl2rgba_levels.sv -----
// ----------------------------------------------------------------------------
// HSL to RGBA level stages
// Stages one to three: low and high levels, their spread and hue weights.
// ----------------------------------------------------------------------------
module hsl2rgba_levels (
  input  logic                 clk,
  input  hsl2rgba_pkg::ctrl_t  ctrl,
  input  logic [15:0]          hue,
  input  logic [15:0]          saturation,
  input  logic [15:0]          lightness,
  output logic [31:0]          lo,
  output logic [31:0]          spread,
  output logic [16:0]          k_red,
  output logic [16:0]          k_green,
  output logic [16:0]          k_blue
);
  import hsl2rgba_pkg::*;

  // Stage 1 registers
  logic [15:0] l1;
  logic [15:0] s1;
  logic [31:0] ls1;
  logic [17:0] th1;

  // Stage 2 registers
  logic [31:0] hi2;
  logic [32:0] two_l2;
  logic [16:0] kr2;
  logic [16:0] kg2;
  logic [16:0] kb2;

  // Stage 2 logic
  logic [31:0] l_one;
  logic [16:0] l_plus_s;
  logic [33:0] hi_low;
  logic [33:0] hi_high;

  // Stage 3 logic
  logic [33:0] diff_lo;
  logic [33:0] diff_d;
  logic        lo_clamped;

  // Stage 1: product l*s and scaled hue
  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      l1  <= lightness;
      s1  <= saturation;
      ls1 <= lightness * saturation;
      th1 <= {2'b00, hue} + {1'b0, hue, 1'b0};
    end
  end

  // Stage 2: high level for either lightness half
  always_comb begin
    l_one    = {l1, 16'h0000} - {16'h0000, l1};
    l_plus_s = {1'b0, l1} + {1'b0, s1};
    hi_low   = {2'b00, l_one} + {2'b00, ls1};
    hi_high  = {1'b0, l_plus_s, 16'h0000} - {17'd0, l_plus_s} - {2'b00, ls1};
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      hi2    <= (l1[15] == 1'b0) ? hi_low[31:0] : hi_high[31:0];
      two_l2 <= {l_one, 1'b0};
      kr2    <= hue_ramp(wrap_hue(th1, TURN));
      kg2    <= hue_ramp(th1);
      kb2    <= hue_ramp(wrap_hue(th1, TWO_TURNS));
    end
  end

  // Stage 3: low level and spread, both clamped at zero
  always_comb begin
    diff_lo    = {1'b0, two_l2} - {2'b00, hi2};
    diff_d     = {1'b0, hi2, 1'b0} - {1'b0, two_l2};
    lo_clamped = diff_lo[33] || (diff_lo == 34'd0);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      lo      <= lo_clamped ? 32'd0 : diff_lo[31:0];
      spread  <= lo_clamped ? hi2 : (diff_d[33] ? 32'd0 : diff_d[31:0]);
      k_red   <= kr2;
      k_green <= kg2;
      k_blue  <= kb2;
    end
  end

endmodule

// ----- rtl/hsl2rgba_channel.sv -----
// ----------------------------------------------------------------------------
// HSL to RGBA channel stages
// Stages four to six: weight the spread, round, scale by 1/ONE, saturate.
// ----------------------------------------------------------------------------
module hsl2rgba_channel (
  input  logic                 clk,
  input  hsl2rgba_pkg::ctrl_t  ctrl,
  input  logic [31:0]          lo,
  input  logic [31:0]          spread,
  input  logic [16:0]          weight,
  output logic [15:0]          value
);
  import hsl2rgba_pkg::*;

  // Stage 4 registers
  logic [48:0] prod4;
  logic [31:0] lo4;

  // Stage 5 register
  logic [31:0] y5;

  // Stage 5 and 6 logic
  logic [33:0] y_sum;
  logic [16:0] fold;
  logic [16:0] quot;

  // Stage 4: spread times hue weight
  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      prod4 <= spread * weight;
      lo4   <= lo;
    end
  end

  // Stage 5: add low level, rounding bias and the half-bit
  always_comb begin
    y_sum = {2'b00, lo4} + {1'b0, prod4[48:16]} + {18'd0, ROUND_BIAS}
          + {33'd0, prod4[15]};
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[4]) begin
      y5 <= y_sum[31:0];
    end
  end

  // Stage 6: divide by 2^16-1 via high plus low fold, then saturate
  always_comb begin
    fold = {1'b0, y5[31:16]} + {1'b0, y5[15:0]};
    if (fold >= TWO_UNITS)
      quot = {1'b0, y5[31:16]} + 17'd2;
    else if (fold >= {1'b0, UNIT_ONE})
      quot = {1'b0, y5[31:16]} + 17'd1;
    else
      quot = {1'b0, y5[31:16]};
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[5]) begin
      value <= quot[16] ? UNIT_ONE : quot[15:0];
    end
  end

endmodule

// ----- rtl/hsl_to_rgba_converter.sv -----
// ----------------------------------------------------------------------------
// HSL to RGBA converter
// Six-stage pipeline turning one HSL pixel with alpha into RGBA per clock unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis carries one pixel per transfer: hue, saturation,
//   lightness (16-bit fractions) and an alpha byte. Output stream m_axis
//   carries one RGBA pixel per transfer: red, green, blue and opacity as
//   0.16 fractions, saturated to one.
//   An input transfer appears on m_axis once it has passed through every
//   register stage. Throughput is one pixel per cycle while m_axis_tready
//   stays high; the six register stages each hold one pixel and the one
//   32x17 multiply per channel in stage four sets the cycle budget.
//   Reset clears all stage valid bits; the pipeline comes up empty and ready.
//   When the receiver stalls, the result holds on m_axis; earlier stages
//   keep advancing into empty slots, and s_axis_tready drops only once every
//   stage holds a pixel. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module hsl_to_rgba_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // hue [15:0], saturation [31:16], lightness [47:32], alpha [55:48]
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // red [15:0], green [31:16], blue [47:32], opacity [63:48]
  output logic [63:0] m_axis_tdata
);
  import hsl2rgba_pkg::*;

  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES-1:0] ready;
  ctrl_t                 ctrl;
  logic [7:0]            alpha_pipe [NUM_STAGES];

  logic [31:0] lo;
  logic [31:0] spread;
  logic [16:0] k_red;
  logic [16:0] k_green;
  logic [16:0] k_blue;
  logic [15:0] red;
  logic [15:0] green;
  logic [15:0] blue;

  // A stage takes new data when empty or when its contents move on
  always_comb begin
    ready[NUM_STAGES-1] = !valid[NUM_STAGES-1] || m_axis_tready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      ready[i] = !valid[i] || ready[i+1];
    end
    ctrl.load = ready;
  end

  assign s_axis_tready = ready[0];

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ready[0]) begin
        valid[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (ready[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  // Carry alpha alongside the color stages
  always_ff @(posedge clk) begin
    if (ready[0]) begin
      alpha_pipe[0] <= s_axis_tdata[55:48];
    end
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (ready[i]) begin
        alpha_pipe[i] <= alpha_pipe[i-1];
      end
    end
  end

  hsl2rgba_levels u_levels (
    .clk        (clk),
    .ctrl       (ctrl),
    .hue        (s_axis_tdata[15:0]),
    .saturation (s_axis_tdata[31:16]),
    .lightness  (s_axis_tdata[47:32]),
    .lo         (lo),
    .spread     (spread),
    .k_red      (k_red),
    .k_green    (k_green),
    .k_blue     (k_blue)
  );

  hsl2rgba_channel u_red (
    .clk    (clk),
    .ctrl   (ctrl),
    .lo     (lo),
    .spread (spread),
    .weight (k_red),
    .value  (red)
  );

  hsl2rgba_channel u_green (
    .clk    (clk),
    .ctrl   (ctrl),
    .lo     (lo),
    .spread (spread),
    .weight (k_green),
    .value  (green)
  );

  hsl2rgba_channel u_blue (
    .clk    (clk),
    .ctrl   (ctrl),
    .lo     (lo),
    .spread (spread),
    .weight (k_blue),
    .value  (blue)
  );

  // Opacity is alpha times 257: the byte repeated
  assign m_axis_tvalid = valid[NUM_STAGES-1];
  assign m_axis_tdata  = {alpha_pipe[NUM_STAGES-1], alpha_pipe[NUM_STAGES-1], blue, green, red};

endmodule

// ----- rtl/hsl2rgba_checker.sv -----
// ----------------------------------------------------------------------------
// HSL to RGBA converter checker
// Port-level checks on the converter streams, bound to the top level.
// ----------------------------------------------------------------------------
`include "hsl_to_rgba_converter_defines.svh"

module hsl2rgba_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  // Stalled result keeps valid and data
  `HSL2RGBA_ASSERT_NEXT(a_out_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `HSL2RGBA_ASSERT_NEXT(a_out_hold_data, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

  // Reset empties the pipeline
  `HSL2RGBA_ASSERT_RESET(a_reset_empty, rst, !m_axis_tvalid)

  // An empty output stage never blocks the input
  `HSL2RGBA_ASSERT_NOW(a_ready_when_drained, !m_axis_tvalid, s_axis_tready)

  // Opacity is the alpha byte repeated
  `HSL2RGBA_ASSERT_NOW(a_opacity_form, m_axis_tvalid, m_axis_tdata[63:56] == m_axis_tdata[55:48])

endmodule

bind hsl_to_rgba_converter hsl2rgba_checker u_hsl2rgba_checker (.*);
